FILE: hdl/rsa_pkg.sv
// rsa_pkg: sizes, opcodes and bit-mask helpers for the refcounted slot allocator
// no dependencies; used by refcounted_slot_allocator and rsa_checker
package rsa_pkg;

    localparam int MAX_SLOTS  = 4096;
    localparam int COUNT_BITS = 16;
    localparam int SLOT_W     = 13;
    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORD_COUNT = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = $clog2(WORD_COUNT);
    localparam int POS_W      = $clog2(MAX_SLOTS);
    localparam int VISIT_W    = $clog2(WORD_COUNT + 2);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SLOT_W-1:0]     CFG_RESET = 13'd4096;

    typedef logic [1:0]           t_opcode;
    typedef logic [WORD_BITS-1:0] t_word;

    localparam t_opcode OP_ALLOC   = 2'd0;
    localparam t_opcode OP_RETAIN  = 2'd1;
    localparam t_opcode OP_RELEASE = 2'd2;
    localparam t_opcode OP_QUERY   = 2'd3;

    // lowest set bit, 0 when none
    function automatic logic [BIT_W-1:0] first_set(input t_word w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // ones at bit positions 0..k
    function automatic t_word mask_upto(input logic [BIT_W-1:0] k);
        t_word ones;
        ones = '1;
        return ones >> (BIT_W'(WORD_BITS - 1) - k);
    endfunction

endpackage

FILE: hdl/refcounted_slot_allocator.sv
// refcounted_slot_allocator: next-fit slot allocator with per-slot reference counts
// depends on rsa_pkg and rsa_ram (used bitmap and count store)
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  in       | i_in_valid / o_in_stall   | i_opcode, i_slot_index
//  out      | o_out_valid / i_out_stall | o_slot_given, o_ref_count, o_status
//  cfg      | i_cfg_we                  | i_cfg_data (slot count)
//
// one word at a time; retain, release and query go through START and RMW to EMIT (START to EMIT if invalid)
// allocate goes through START, SCAN and EMIT (START to EMIT for an empty pool): the bitmap ram
// is read one 64-slot word per cycle from the next-fit cursor around the pool
// reset clears control state and word-valid flags; no clearing pass is needed
// a stalled result sits in the output register; the next word is taken meanwhile
module refcounted_slot_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rsa_pkg::SLOT_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  rsa_pkg::t_opcode           i_opcode,
    input  logic [rsa_pkg::SLOT_W-1:0] i_slot_index,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [rsa_pkg::SLOT_W-1:0] o_slot_given,
    output logic [rsa_pkg::COUNT_BITS-1:0] o_ref_count,
    output logic                       o_status
);

    localparam int SW = rsa_pkg::SLOT_W;
    localparam int CW = rsa_pkg::COUNT_BITS;
    localparam int PW = rsa_pkg::POS_W;
    localparam int AW = rsa_pkg::WORD_AW;
    localparam int BW = rsa_pkg::BIT_W;
    localparam int VW = rsa_pkg::VISIT_W;
    localparam int WC = rsa_pkg::WORD_COUNT;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_RMW   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [SW-1:0]          r_slot_count, n_slot_count;
    logic [SW-1:0]          r_cursor, n_cursor;
    logic [WC-1:0]          r_word_vld, n_word_vld;
    logic                   r_chk_vld, n_chk_vld;
    logic                   r_out_valid, n_out_valid;

    rsa_pkg::t_opcode       r_op, n_op;
    logic [SW-1:0]          r_slot, n_slot;
    logic [AW-1:0]          r_iss_word, n_iss_word;
    logic [VW-1:0]          r_iss_left, n_iss_left;
    logic                   r_iss_first, n_iss_first;
    logic [AW-1:0]          r_wlast, n_wlast;
    logic [BW-1:0]          r_off, n_off;
    rsa_pkg::t_word         r_last_mask, n_last_mask;
    logic [AW-1:0]          r_chk_word, n_chk_word;
    rsa_pkg::t_word         r_chk_mask, n_chk_mask;
    logic                   r_chk_last, n_chk_last;
    logic [SW-1:0]          r_res_given, n_res_given;
    logic [CW-1:0]          r_res_cnt, n_res_cnt;
    logic                   r_res_err, n_res_err;
    logic [SW-1:0]          r_out_given, n_out_given;
    logic [CW-1:0]          r_out_cnt, n_out_cnt;
    logic                   r_out_err, n_out_err;

    logic                   bm_we;
    logic [AW-1:0]          bm_waddr, bm_raddr;
    rsa_pkg::t_word         bm_wdata, bm_rdata;
    logic                   rc_we;
    logic [PW-1:0]          rc_waddr, rc_raddr;
    logic [CW-1:0]          rc_wdata, rc_rdata;

    logic [SW-1:0]          live_n, n_m1, start_slot, start_m1, slot_m1;
    logic [SW-1:0]          found_slot;
    logic                   slot_ok, out_free, used;
    rsa_pkg::t_word         ones, iss_range, iss_mask, chk_data, free_bits, rmw_word;
    logic [BW-1:0]          fbit;
    logic [PW-1:0]          pos;

    rsa_ram #(.WIDTH(rsa_pkg::WORD_BITS), .DEPTH(WC)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    rsa_ram #(.WIDTH(CW), .DEPTH(rsa_pkg::MAX_SLOTS)) u_counts (
        .i_clk   (i_clk),
        .i_we    (rc_we),
        .i_waddr (rc_waddr),
        .i_wdata (rc_wdata),
        .i_raddr (rc_raddr),
        .o_rdata (rc_rdata)
    );

    assign ones       = '1;
    assign live_n     = (r_slot_count > SW'(rsa_pkg::MAX_SLOTS)) ? SW'(rsa_pkg::MAX_SLOTS)
                                                                 : r_slot_count;
    assign n_m1       = live_n - SW'(1);
    assign start_slot = (r_cursor == '0 || r_cursor > live_n) ? SW'(1) : r_cursor;
    assign start_m1   = start_slot - SW'(1);
    assign slot_m1    = r_slot - SW'(1);
    assign slot_ok    = (r_slot != '0) && (r_slot <= live_n);
    assign out_free   = !r_out_valid || !i_out_stall;

    // scan issue mask
    assign iss_range = (r_iss_word == r_wlast) ? r_last_mask : ones;
    always_comb begin
        if (r_iss_first) begin
            iss_mask = iss_range & (ones << r_off);
        end else if (r_iss_left == VW'(1) && r_off != '0) begin
            iss_mask = ~(ones << r_off);
        end else begin
            iss_mask = iss_range;
        end
    end

    // scan check
    assign chk_data   = r_word_vld[r_chk_word] ? bm_rdata : '0;
    assign free_bits  = ~chk_data & r_chk_mask;
    assign fbit       = rsa_pkg::first_set(free_bits);
    assign found_slot = {1'b0, r_chk_word, fbit} + SW'(1);

    // retain, release, query
    assign pos      = slot_m1[PW-1:0];
    assign rmw_word = r_word_vld[pos[PW-1:BW]] ? bm_rdata : '0;
    assign used     = rmw_word[pos[BW-1:0]];

    always_comb begin
        n_state      = r_state;
        n_slot_count = i_cfg_we ? i_cfg_data : r_slot_count;
        n_cursor     = r_cursor;
        n_chk_vld    = 1'b0;
        n_op         = r_op;
        n_slot       = r_slot;
        n_iss_word   = r_iss_word;
        n_iss_left   = r_iss_left;
        n_iss_first  = r_iss_first;
        n_wlast      = r_wlast;
        n_off        = r_off;
        n_last_mask  = r_last_mask;
        n_chk_word   = r_iss_word;
        n_chk_mask   = iss_mask;
        n_chk_last   = (r_iss_left == VW'(1));
        n_res_given  = r_res_given;
        n_res_cnt    = r_res_cnt;
        n_res_err    = r_res_err;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_given  = r_out_given;
        n_out_cnt    = r_out_cnt;
        n_out_err    = r_out_err;
        bm_we        = 1'b0;
        bm_waddr     = r_chk_word;
        bm_wdata     = chk_data | (rsa_pkg::t_word'(1) << fbit);
        bm_raddr     = r_iss_word;
        rc_we        = 1'b0;
        rc_waddr     = {r_chk_word, fbit};
        rc_wdata     = CW'(1);
        rc_raddr     = pos;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_opcode;
                    n_slot  = i_slot_index;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_res_given = '0;
                n_res_cnt   = '0;
                n_res_err   = 1'b1;
                if (r_op == rsa_pkg::OP_ALLOC) begin
                    n_wlast     = n_m1[PW-1:BW];
                    n_last_mask = rsa_pkg::mask_upto(n_m1[BW-1:0]);
                    n_off       = start_m1[BW-1:0];
                    n_iss_word  = start_m1[PW-1:BW];
                    n_iss_first = 1'b1;
                    n_iss_left  = VW'(n_m1[PW-1:BW]) + VW'(1)
                                + VW'(start_m1[BW-1:0] != '0);
                    n_state     = (live_n == '0) ? ST_EMIT : ST_SCAN;
                end else begin
                    bm_raddr = pos[PW-1:BW];
                    n_state  = slot_ok ? ST_RMW : ST_EMIT;
                end
            end
            ST_SCAN: begin
                if (r_iss_left != '0) begin
                    n_chk_vld   = 1'b1;
                    n_iss_left  = r_iss_left - VW'(1);
                    n_iss_first = 1'b0;
                    n_iss_word  = (r_iss_word == r_wlast) ? '0 : r_iss_word + AW'(1);
                end
                if (r_chk_vld) begin
                    if (free_bits != '0) begin
                        bm_we       = 1'b1;
                        rc_we       = 1'b1;
                        n_cursor    = (found_slot == live_n) ? SW'(1) : found_slot + SW'(1);
                        n_res_given = found_slot;
                        n_res_cnt   = CW'(1);
                        n_res_err   = 1'b0;
                        n_chk_vld   = 1'b0;
                        n_state     = ST_EMIT;
                    end else if (r_chk_last) begin
                        n_chk_vld = 1'b0;
                        n_state   = ST_EMIT;
                    end
                end
            end
            ST_RMW: begin
                bm_waddr = pos[PW-1:BW];
                bm_wdata = rmw_word & ~(rsa_pkg::t_word'(1) << pos[BW-1:0]);
                rc_waddr = pos;
                if (used && rc_rdata != '0) begin
                    case (r_op)
                        rsa_pkg::OP_RETAIN: begin
                            if (rc_rdata != rsa_pkg::COUNT_MAX) begin
                                rc_we     = 1'b1;
                                rc_wdata  = rc_rdata + CW'(1);
                                n_res_cnt = rc_rdata + CW'(1);
                                n_res_err = 1'b0;
                            end else begin
                                n_res_cnt = rc_rdata;
                            end
                        end
                        rsa_pkg::OP_RELEASE: begin
                            rc_we     = 1'b1;
                            rc_wdata  = rc_rdata - CW'(1);
                            bm_we     = (rc_rdata == CW'(1));
                            n_res_cnt = rc_rdata - CW'(1);
                            n_res_err = 1'b0;
                        end
                        default: begin
                            n_res_cnt = rc_rdata;
                            n_res_err = 1'b0;
                        end
                    endcase
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_given = r_res_given;
                    n_out_cnt   = r_res_cnt;
                    n_out_err   = r_res_err;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_word_vld = r_word_vld | (bm_we ? (WC'(1) << bm_waddr) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slot_count <= rsa_pkg::CFG_RESET;
            r_cursor     <= SW'(1);
            r_word_vld   <= '0;
            r_chk_vld    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot_count <= n_slot_count;
            r_cursor     <= n_cursor;
            r_word_vld   <= n_word_vld;
            r_chk_vld    <= n_chk_vld;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_slot      <= n_slot;
        r_iss_word  <= n_iss_word;
        r_iss_left  <= n_iss_left;
        r_iss_first <= n_iss_first;
        r_wlast     <= n_wlast;
        r_off       <= n_off;
        r_last_mask <= n_last_mask;
        r_chk_word  <= n_chk_word;
        r_chk_mask  <= n_chk_mask;
        r_chk_last  <= n_chk_last;
        r_res_given <= n_res_given;
        r_res_cnt   <= n_res_cnt;
        r_res_err   <= n_res_err;
        r_out_given <= n_out_given;
        r_out_cnt   <= n_out_cnt;
        r_out_err   <= n_out_err;
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_slot_given = r_out_given;
    assign o_ref_count  = r_out_cnt;
    assign o_status     = r_out_err;

endmodule

FILE: hdl/rsa_ram.sv
// rsa_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module rsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/rsa_checker.sv
// rsa_checker: port-level assertions for refcounted_slot_allocator, bound to the top
// depends on rsa_pkg
module rsa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [rsa_pkg::SLOT_W-1:0]     o_slot_given,
    input logic [rsa_pkg::COUNT_BITS-1:0] o_ref_count,
    input logic                           o_status
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_slot_given)
            && $stable(o_ref_count) && $stable(o_status))
        else $error("stalled result word changed");

    // one word in flight: busy right after accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // a granted slot is never an error
    a_given_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_slot_given != '0 |-> !o_status)
        else $error("slot granted with error status");

    // a fresh allocation starts at count one
    a_given_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_slot_given != '0 |-> o_ref_count == rsa_pkg::COUNT_BITS'(1))
        else $error("granted slot count is not one");

endmodule

bind refcounted_slot_allocator rsa_checker u_rsa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_slot_given (o_slot_given),
    .o_ref_count  (o_ref_count),
    .o_status     (o_status)
);
